// ===== hdl/periodic_step_catchup_sequencer_macros.svh =====
// Assertion macros shared by the step sequencer checker.
`ifndef PERIODIC_STEP_CATCHUP_SEQUENCER_MACROS_SVH
`define PERIODIC_STEP_CATCHUP_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PSCS_ASSERT_NOW(label, cond, expect_now) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (expect_now)) else $error("pscs same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PSCS_ASSERT_NEXT(label, cond, expect_next) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_next)) else $error("pscs next-cycle check failed");

`endif

// ===== hdl/pscs_pkg.sv =====
// Shared types and constants of the periodic step catch-up sequencer.
`default_nettype none
package pscs_pkg;

    localparam int PERIOD_W      = 16;
    localparam int STEPS_W       = 4;
    localparam int ACTIONS_W     = 32;
    localparam int ACTION_SLOTS  = 8;
    localparam int ACTION_W      = 4;
    localparam int GAZE_W        = 3;
    localparam int SLOT_OUT_W    = 3;
    localparam int STEP_NUMBER_W = 34;
    localparam int OUT_FIELDS_W  = SLOT_OUT_W + GAZE_W + 1 + STEP_NUMBER_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd4800;
    localparam logic [STEPS_W-1:0]  STEPS_RESET  = 4'd1;
    localparam logic [GAZE_W-1:0]   GAZE_MAX     = 3'd5;
    localparam logic [GAZE_W-1:0]   GAZE_NONE    = 3'd0;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEPS        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSETS_LOW  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSETS_HIGH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIONS      = 3'd4;

    // Cleaned-up view of the timing registers
    typedef struct packed {
        logic [PERIOD_W-1:0] period;   // never zero
        logic [STEPS_W-1:0]  steps;    // 1 .. min(15, MAX_STEPS)
    } cfg_view_t;

    typedef struct packed {
        logic              blink;
        logic [GAZE_W-1:0] gaze;       // undefined codes already mapped to none
    } step_action_t;

endpackage
`default_nettype wire

// ===== hdl/pscs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module pscs_div
    import pscs_pkg::*;
#(
    parameter int DIVIDEND_W = 31
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [PERIOD_W-1:0]   divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient,
    output logic [PERIOD_W-1:0]        remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [PERIOD_W-1:0]   rem_reg, rem_next;
    logic [PERIOD_W-1:0]   dvs_reg, dvs_next;
    logic [PERIOD_W:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quot_reg[DIVIDEND_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = PERIOD_W'(trial - {1'b0, dvs_reg});
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[PERIOD_W-1:0];
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ===== hdl/pscs_cfg.sv =====
// Configuration registers with offset and action lookup by slot.
`default_nettype none
module pscs_cfg
    import pscs_pkg::*;
#(
    parameter int MAX_STEPS   = 8,
    parameter int OFFSET_BITS = 16,
    parameter int SLOT_W      = 3
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_view_t                   view,
    input  wire logic [SLOT_W-1:0]      scan_slot,
    output logic [OFFSET_BITS-1:0]      scan_offset,
    input  wire logic [SLOT_W-1:0]      emit_slot,
    output step_action_t                emit_action
);

    localparam int PER_REG = CFG_DATA_W / OFFSET_BITS;

    logic [PERIOD_W-1:0]   period_reg;
    logic [STEPS_W-1:0]    steps_reg;
    logic [CFG_DATA_W-1:0] offs_low_reg;
    logic [CFG_DATA_W-1:0] offs_high_reg;
    logic [ACTIONS_W-1:0]  actions_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RESET;
            steps_reg     <= STEPS_RESET;
            offs_low_reg  <= '0;
            offs_high_reg <= '0;
            actions_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PERIOD:       period_reg    <= cfg_data[PERIOD_W-1:0];
                REG_STEPS:        steps_reg     <= cfg_data[STEPS_W-1:0];
                REG_OFFSETS_LOW:  offs_low_reg  <= cfg_data;
                REG_OFFSETS_HIGH: offs_high_reg <= cfg_data;
                REG_ACTIONS:      actions_reg   <= cfg_data[ACTIONS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Zero period acts as one; step count clamped to 1..MAX_STEPS
    always_comb
    begin
        view.period = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
        if (steps_reg == '0)
            view.steps = STEPS_W'(1);
        else if (int'(steps_reg) > MAX_STEPS)
            view.steps = STEPS_W'(MAX_STEPS);
        else
            view.steps = steps_reg;
    end

    // Offset lookup; slots past both registers read as zero
    logic [CFG_DATA_W-1:0] offs_sel;
    logic [CFG_DATA_W-1:0] offs_shifted;
    int                    offs_pos;

    always_comb
    begin
        if (int'(scan_slot) < PER_REG)
        begin
            offs_sel = offs_low_reg;
            offs_pos = int'(scan_slot);
        end
        else if (int'(scan_slot) < 2 * PER_REG)
        begin
            offs_sel = offs_high_reg;
            offs_pos = int'(scan_slot) - PER_REG;
        end
        else
        begin
            offs_sel = '0;
            offs_pos = 0;
        end
        offs_shifted = offs_sel >> (offs_pos * OFFSET_BITS);
        scan_offset  = offs_shifted[OFFSET_BITS-1:0];
    end

    // Action lookup; gaze codes above GAZE_MAX map to none
    logic [ACTIONS_W-1:0] act_shifted;
    logic [ACTION_W-1:0]  act_raw;

    always_comb
    begin
        act_shifted = actions_reg >> (ACTION_W * int'(emit_slot));
        if (int'(emit_slot) < ACTION_SLOTS)
            act_raw = act_shifted[ACTION_W-1:0];
        else
            act_raw = '0;
        emit_action.blink = act_raw[ACTION_W-1];
        emit_action.gaze  = (act_raw[GAZE_W-1:0] > GAZE_MAX) ? GAZE_NONE
                                                             : act_raw[GAZE_W-1:0];
    end

endmodule
`default_nettype wire

// ===== hdl/periodic_step_catchup_sequencer.sv =====
// Top level of the periodic step catch-up sequencer.
//
//   Channel   Direction  Handshake                Payload
//   s_axis    in         s_axis_tvalid/tready     elapsed_ticks
//   m_axis    out        m_axis_tvalid/tready     step fields, tlast = last
//   cfg       in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// The first step reaches m_axis after the query transfer has passed through the
// one-bit-per-cycle divider, the hand-over of its result, the offset scan (one
// active slot per cycle), then multiply, difference, setup and the output load.
// Each further due step follows one per cycle while m_axis_tready is high; a
// negative time skips the divider and the scan and emits no steps.
// s_axis_tready is high only while the sequencer is idle. A stall on m_axis
// holds the output register and the sequencer. Reset (rst_n low) clears the
// fired count and loads the register defaults; no clearing pass is needed.
`default_nettype none
module periodic_step_catchup_sequencer
    import pscs_pkg::*;
#(
    parameter int MAX_STEPS    = 8,
    parameter int OFFSET_BITS  = 16,
    parameter int ELAPSED_BITS = 32,
    localparam int IN_TDATA_W  = ((ELAPSED_BITS + 7) / 8) * 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [ELAPSED_BITS-1:0] elapsed_ticks (signed), rest zero padding
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [2:0] step_slot, [5:3] gaze_code, [6] blink, [40:7] step_number,
    // rest zero padding
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tlast,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_W  = $clog2(MAX_STEPS);
    localparam int QUOT_W  = ELAPSED_BITS - 1;
    localparam int CNT_W   = QUOT_W + STEPS_W;   // holds periods * steps + steps

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SCAN,
        ST_MULT,
        ST_DIFF,
        ST_SETUP,
        ST_EMIT
    } state_t;

    cfg_view_t           view;
    logic [OFFSET_BITS-1:0] scan_offset;
    step_action_t        emit_action;

    logic                div_start;
    logic                div_done;
    logic [QUOT_W-1:0]   div_quot;
    logic [PERIOD_W-1:0] div_rem;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [STEPS_W-1:0]  hits_reg, hits_next;
    logic [CNT_W-1:0]    target_reg, target_next;
    logic [CNT_W-1:0]    fired_reg, fired_next;
    logic [CNT_W:0]      diff_reg, diff_next;
    logic [STEPS_W-1:0]  remain_reg, remain_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    pscs_cfg #(
        .MAX_STEPS   (MAX_STEPS),
        .OFFSET_BITS (OFFSET_BITS),
        .SLOT_W      (SLOT_W)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .view        (view),
        .scan_slot   (scan_idx_reg),
        .scan_offset (scan_offset),
        .emit_slot   (slot_reg),
        .emit_action (emit_action)
    );

    pscs_div #(
        .DIVIDEND_W (QUOT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (s_axis_tdata[QUOT_W-1:0]),
        .divisor   (view.period),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);

    logic                  in_xfer;
    logic                  out_free;
    logic [STEPS_W-1:0]    count;
    logic [STEPS_W-1:0]    tmod;
    logic [STEPS_W:0]      slot_wide;
    logic [CNT_W-1:0]      product;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        hits_next      = hits_reg;
        target_next    = target_reg;
        fired_next     = fired_reg;
        diff_next      = diff_reg;
        remain_next    = remain_reg;
        slot_next      = slot_reg;
        k_next         = k_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        div_start      = 1'b0;
        count          = '0;
        tmod           = '0;
        slot_wide      = '0;
        product        = CNT_W'(div_quot) * CNT_W'(view.steps);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tdata[ELAPSED_BITS-1])
                    begin
                        // negative time: target is zero
                        target_next = '0;
                        hits_next   = '0;
                        state_next  = ST_DIFF;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                scan_idx_next = '0;
                hits_next     = '0;
                if (div_done)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // one offset compare per cycle
                if (32'(scan_offset) <= 32'(div_rem))
                    hits_next = hits_reg + STEPS_W'(1);
                scan_idx_next = scan_idx_reg + SLOT_W'(1);
                if (32'(scan_idx_reg) + 32'd1 == 32'(view.steps))
                    state_next = ST_MULT;
            end
            ST_MULT:
            begin
                target_next = product + CNT_W'(hits_reg);
                state_next  = ST_DIFF;
            end
            ST_DIFF:
            begin
                diff_next  = {1'b0, target_reg} - {1'b0, fired_reg};
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                fired_next = target_reg;
                if (diff_reg[CNT_W] || diff_reg == '0)
                begin
                    // time did not move forward: nothing due
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (diff_reg >= (CNT_W+1)'(view.steps))
                        count = view.steps;
                    else
                        count = diff_reg[STEPS_W-1:0];
                    tmod = (hits_reg == view.steps) ? '0 : hits_reg;
                    // first slot = (target - count) mod steps
                    slot_wide = {1'b0, tmod} - {1'b0, count};
                    if (tmod < count)
                        slot_wide = slot_wide + {1'b0, view.steps};
                    slot_next   = slot_wide[SLOT_W-1:0];
                    k_next      = target_reg - CNT_W'(count);
                    remain_next = count;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = (remain_reg == STEPS_W'(1));
                    out_data_next  = {{OUT_PAD_W{1'b0}},
                                      STEP_NUMBER_W'(k_reg),
                                      emit_action.blink,
                                      emit_action.gaze,
                                      SLOT_OUT_W'(slot_reg)};
                    k_next      = k_reg + CNT_W'(1);
                    remain_next = remain_reg - STEPS_W'(1);
                    if (32'(slot_reg) + 32'd1 == 32'(view.steps))
                        slot_next = '0;
                    else
                        slot_next = slot_reg + SLOT_W'(1);
                    if (remain_reg == STEPS_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fired_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fired_reg     <= fired_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        hits_reg     <= hits_next;
        target_reg   <= target_next;
        diff_reg     <= diff_next;
        remain_reg   <= remain_next;
        slot_reg     <= slot_next;
        k_reg        <= k_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ===== hdl/pscs_checker.sv =====
// Port-level checker for the step sequencer, bound to the top level.
`default_nettype none
`include "periodic_step_catchup_sequencer_macros.svh"
module pscs_checker
    import pscs_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tlast
);

    // one query in flight: input closes right after a transfer
    `PSCS_ASSERT_NEXT(a_busy_after_query, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // no new query while a burst still has steps to come
    `PSCS_ASSERT_NOW(a_no_query_mid_burst, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

    // stalled result holds
    `PSCS_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind periodic_step_catchup_sequencer pscs_checker u_pscs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
